// ===== rtl/tlvlsi_pkg.sv =====
`default_nettype none

package tlvlsi_pkg;

  localparam int INDEX_DEPTH   = 64;
  localparam int IDX_BITS      = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(INDEX_DEPTH + 1);
  localparam int POSITION_BITS = 20;

  localparam int CMD_BITS    = 2;
  localparam int TAG_BITS    = 16;
  localparam int LEN_BITS    = 16;
  localparam int OFFSET_BITS = 20;

  localparam logic [CMD_BITS-1:0] CMD_DATA   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_BITS-1:0]    length;
  } idx_entry_t;

  // Search request: scan entries below count for key.
  typedef struct packed {
    logic                start;
    logic [TAG_BITS-1:0] key;
    logic [CNT_BITS-1:0] count;
  } idx_req_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    idx_entry_t          entry;
  } idx_wr_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    idx_entry_t entry;
  } idx_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tlvlsi_index.sv =====
`default_nettype none

module tlvlsi_index
  import tlvlsi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire idx_req_t req,
  input  wire idx_wr_t  wr,
  output idx_rsp_t      rsp
);

  idx_entry_t mem [INDEX_DEPTH];

  logic                scanning;
  logic                rd_pend;
  logic                rd_last;
  logic                empty_done;
  logic [CNT_BITS-1:0] addr;
  logic [CNT_BITS-1:0] count_q;
  logic [TAG_BITS-1:0] key_q;
  idx_entry_t          rd_data;
  logic                match;
  logic [CNT_BITS-1:0] addr_inc;

  assign addr_inc = addr + CNT_BITS'(1);
  assign match    = rd_pend && (rd_data.tag == key_q);

  always_comb begin
    rsp.done  = empty_done || (rd_pend && (match || rd_last));
    rsp.hit   = match;
    rsp.entry = rd_data;
  end

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (scanning) begin
      rd_data <= mem[addr[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      key_q   <= req.key;
      count_q <= req.count;
      addr    <= '0;
    end else if (scanning) begin
      rd_last <= (addr_inc == count_q);
      addr    <= addr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      rd_pend    <= 1'b0;
      empty_done <= 1'b0;
    end else if (req.start) begin
      scanning   <= (req.count != '0);
      rd_pend    <= 1'b0;
      empty_done <= (req.count == '0);
    end else begin
      empty_done <= 1'b0;
      if (rsp.done) begin
        // stop on first match or after the last live entry
        scanning <= 1'b0;
        rd_pend  <= 1'b0;
      end else if (scanning) begin
        rd_pend <= 1'b1;
        if (addr_inc == count_q) begin
          scanning <= 1'b0;
        end
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlv_local_set_indexer.sv =====
// Data words: staged, then registered into the output; one word per cycle sustained while out_ready holds.
// Length-low data words and lookups scan the index RAM one entry per cycle,
//   reading at most entry_count entries and stopping at the first match.
// The scan of the index RAM sets the rate of those words.
// Reset clears the parser, flags and entry count; the index RAM is not cleared,
//   since only entries below entry_count are ever read.
`default_nettype none

module tlv_local_set_indexer
  import tlvlsi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_BITS-1:0]    cmd,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire logic [TAG_BITS-1:0]    lookup_tag,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        found,
  output logic [OFFSET_BITS-1:0]      value_offset,
  output logic [LEN_BITS-1:0]         value_length,
  output logic                        set_complete,
  output logic                        malformed,
  output logic                        table_full
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [2:0] {
    PH_TAG_A,
    PH_TAG_B,
    PH_LEN_H,
    PH_LEN_L,
    PH_VALUE,
    PH_ENDED
  } phase_t;

  // Parser state
  state_t                   state, state_next;
  phase_t                   phase, phase_next;
  logic [TAG_BITS-1:0]      tag, tag_next;
  logic [7:0]               len_hi, len_hi_next;
  logic [LEN_BITS-1:0]      skip, skip_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic                     err, err_next;
  logic                     ovf, ovf_next;
  logic [CNT_BITS-1:0]      count, count_next;

  // Context of the word under a scan
  logic op_add, last_q;

  // Result staging between the parser and the output register
  logic                   pend_valid;
  logic                   pend_found;
  logic [OFFSET_BITS-1:0] pend_offset;
  logic [LEN_BITS-1:0]    pend_length;
  logic                   pend_complete;
  logic                   pend_malformed;
  logic                   pend_full;
  logic                   pend_move;

  logic                   res_load;
  logic                   res_found;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [LEN_BITS-1:0]    res_length;

  logic     accept;
  idx_req_t req;
  idx_wr_t  wr;
  idx_rsp_t rsp;

  tlvlsi_index u_index (
    .clk (clk),
    .rst (rst),
    .req (req),
    .wr  (wr),
    .rsp (rsp)
  );

  // Staged result moves on when the output register is free or being drained.
  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = (state == S_IDLE) && (!pend_valid || pend_move);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    tag_next    = tag;
    len_hi_next = len_hi;
    skip_next   = skip;
    pos_next    = pos;
    err_next    = err;
    ovf_next    = ovf;
    count_next  = count;
    req         = '0;
    wr          = '0;
    res_load    = 1'b0;
    res_found   = 1'b0;
    res_offset  = '0;
    res_length  = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (cmd)
            CMD_DATA: begin
              if (phase != PH_ENDED) begin
                pos_next = pos + POSITION_BITS'(1);
                case (phase)
                  PH_TAG_A: begin
                    tag_next   = {8'h00, data_byte};
                    phase_next = PH_TAG_B;
                  end
                  PH_TAG_B: begin
                    tag_next   = {tag[7:0], data_byte};
                    phase_next = PH_LEN_H;
                  end
                  PH_LEN_H: begin
                    len_hi_next = data_byte;
                    phase_next  = PH_LEN_L;
                  end
                  PH_LEN_L: begin
                    // header complete: search for a duplicate before adding
                    skip_next   = {len_hi, data_byte};
                    phase_next  = (skip_next == '0) ? PH_TAG_A : PH_VALUE;
                    req.start   = 1'b1;
                    req.key     = tag;
                    req.count   = count;
                    state_next  = S_SCAN;
                    res_load    = 1'b0;
                  end
                  default: begin
                    skip_next = skip - LEN_BITS'(1);
                    if (skip_next == '0) begin
                      phase_next = PH_TAG_A;
                    end
                  end
                endcase
                // end of set; the length-low word finishes this after its scan
                if (phase != PH_LEN_L && last_byte) begin
                  if (phase_next != PH_TAG_A) begin
                    err_next   = 1'b1;
                    count_next = '0;
                  end
                  phase_next = PH_ENDED;
                end
              end
            end
            CMD_LOOKUP: begin
              req.start  = 1'b1;
              req.key    = lookup_tag;
              req.count  = count;
              state_next = S_SCAN;
              res_load   = 1'b0;
            end
            CMD_START: begin
              phase_next  = PH_TAG_A;
              tag_next    = '0;
              len_hi_next = '0;
              skip_next   = '0;
              pos_next    = '0;
              err_next    = 1'b0;
              ovf_next    = 1'b0;
              count_next  = '0;
            end
            default: begin
              // unused code: hold state, report a miss
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rsp.done) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (op_add) begin
            if (!rsp.hit) begin
              if (count == CNT_BITS'(INDEX_DEPTH)) begin
                ovf_next = 1'b1;
              end else begin
                wr.en           = 1'b1;
                wr.addr         = count[IDX_BITS-1:0];
                wr.entry.tag    = tag;
                wr.entry.offset = OFFSET_BITS'(pos);
                wr.entry.length = skip;
                count_next      = count + CNT_BITS'(1);
              end
            end
            if (last_q) begin
              if (phase != PH_TAG_A) begin
                err_next   = 1'b1;
                count_next = '0;
              end
              phase_next = PH_ENDED;
            end
          end else if (rsp.hit) begin
            res_found  = 1'b1;
            res_offset = rsp.entry.offset;
            res_length = rsp.entry.length;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_TAG_A;
      tag        <= '0;
      len_hi     <= '0;
      skip       <= '0;
      pos        <= '0;
      err        <= 1'b0;
      ovf        <= 1'b0;
      count      <= '0;
      op_add     <= 1'b0;
      last_q     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      tag    <= tag_next;
      len_hi <= len_hi_next;
      skip   <= skip_next;
      pos    <= pos_next;
      err    <= err_next;
      ovf    <= ovf_next;
      count  <= count_next;

      if (accept) begin
        op_add <= (cmd == CMD_DATA);
        last_q <= last_byte;
      end

      if (res_load) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end

      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    // Payload registers: no reset
    if (res_load) begin
      pend_found     <= res_found;
      pend_offset    <= res_offset;
      pend_length    <= res_length;
      pend_complete  <= (phase_next == PH_ENDED) && !err_next;
      pend_malformed <= err_next;
      pend_full      <= ovf_next;
    end
    if (pend_move) begin
      found        <= pend_found;
      value_offset <= pend_offset;
      value_length <= pend_length;
      set_complete <= pend_complete;
      malformed    <= pend_malformed;
      table_full   <= pend_full;
    end
  end

  // The index never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(INDEX_DEPTH))
    else $error("entry count beyond index depth");

  // A new result never lands on a staged word that is not draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!pend_valid || pend_move))
    else $error("staged word overwritten");

  // Scan answers come only while the parser waits for them.
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_SCAN))
    else $error("index answer outside a scan");

  // An entry is written only after a missed duplicate search with room left.
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (rsp.done && !rsp.hit && count < CNT_BITS'(INDEX_DEPTH)))
    else $error("bad index write");

endmodule

`default_nettype wire
